// ----- sv/particle_plane_collision_macros.svh -----
// Assertion macros shared by the particle plane collision RTL.
// PPC_ASSERT checks only while out of reset; PPC_ASSERT_ALWAYS checks at every edge.
`ifndef PARTICLE_PLANE_COLLISION_MACROS_SVH
`define PARTICLE_PLANE_COLLISION_MACROS_SVH

`ifndef ASSERT_OFF
`define PPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPC_ASSERT(lbl, prop, msg)
`define PPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/ppc_pkg.sv -----
package ppc_pkg;

  localparam int Q_W       = 32;
  localparam int N_W       = 18;
  localparam int R_W       = 18;
  localparam int FRAC_BITS = 16;
  localparam int DIST_W    = 52;
  localparam int PROD_W    = N_W + Q_W;
  localparam int CFG_AW    = 3;
  localparam int SAT_W     = 48;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [N_W-1:0] nrm_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_NORMAL_X     = 3'd0,
    REG_NORMAL_Y     = 3'd1,
    REG_NORMAL_Z     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_RESTITUTION  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    q_t [2:0] sp;
    q_t [2:0] ep;
    q_t [2:0] vel;
    logic     last;
  } part_t;

  typedef struct packed {
    nrm_t [2:0]       n;
    q_t               off;
    logic [R_W-1:0]   rest;
  } plane_t;

  function automatic q_t sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7FFF_FFFF);
    lo = -hi - SAT_W'(1);
    if (v > hi) return q_t'(hi);
    if (v < lo) return q_t'(lo);
    return v[Q_W-1:0];
  endfunction

endpackage

// ----- sv/particle_plane_collision.sv -----
// Channel   Direction  Sideband                  Payload
// in_*      slave      in_tlast = in_last        start xyz, end xyz, velocity xyz
// out_*     master     out_tlast, out_tuser      position xyz, velocity xyz
// cfg_*     write      -                         plane normal, offset, restitution
//
// The pipeline has 3 distance stages, 16 divider stages
// (one hit-fraction bit each) and 8 response stages.
// One particle is taken every cycle while the output is not stalled.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// rst_n is synchronous; it clears the valid bits and loads the register defaults.
// Hold in_tready low while rst_n is low, so no transfer is taken in reset.
`include "particle_plane_collision_macros.svh"
module particle_plane_collision (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, vel_x, vel_y, vel_z
  input  logic [287:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z, out_vel_x, out_vel_y, out_vel_z
  output logic [191:0] out_tdata,
  // collided
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [ppc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import ppc_pkg::*;

  plane_t pl_r;
  logic   en;
  part_t  in_p;

  logic               d_v, d_hit;
  part_t              d_p;
  logic [DIST_W-1:0]  d_tot, d_rem;
  logic               q_v, q_hit;
  part_t              q_p;
  logic [FRAC_BITS-1:0] q_frac;
  logic               r_v, r_coll, r_last;
  q_t                 r_pos [3];
  q_t                 r_vel [3];

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r.n[0] <= '0;
      pl_r.n[1] <= nrm_t'(18'sd65536);
      pl_r.n[2] <= '0;
      pl_r.off  <= '0;
      pl_r.rest <= R_W'(65536);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_NORMAL_X:     pl_r.n[0] <= cfg_wdata[N_W-1:0];
        REG_NORMAL_Y:     pl_r.n[1] <= cfg_wdata[N_W-1:0];
        REG_NORMAL_Z:     pl_r.n[2] <= cfg_wdata[N_W-1:0];
        REG_PLANE_OFFSET: pl_r.off  <= cfg_wdata;
        REG_RESTITUTION:  pl_r.rest <= cfg_wdata[R_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished result is waiting.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = rst_n && en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_p.sp[i]  = in_tdata[32*i +: 32];
      in_p.ep[i]  = in_tdata[96 + 32*i +: 32];
      in_p.vel[i] = in_tdata[192 + 32*i +: 32];
    end
    in_p.last = in_tlast;
  end

  ppc_dist u_dist (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(in_tvalid && in_tready), .in_p(in_p), .pl(pl_r),
    .out_v(d_v), .out_p(d_p), .out_hit(d_hit), .out_tot(d_tot), .out_rem(d_rem)
  );

  ppc_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(d_v), .in_p(d_p), .in_hit(d_hit), .in_tot(d_tot), .in_rem(d_rem),
    .out_v(q_v), .out_p(q_p), .out_hit(q_hit), .out_frac(q_frac)
  );

  ppc_resp u_resp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(q_v), .in_p(q_p), .in_hit(q_hit), .in_frac(q_frac), .pl(pl_r),
    .out_v(r_v), .pos(r_pos), .vel(r_vel), .collided(r_coll), .last(r_last)
  );

  assign out_tvalid = r_v;
  assign out_tdata  = {r_vel[2], r_vel[1], r_vel[0], r_pos[2], r_pos[1], r_pos[0]};
  assign out_tuser  = r_coll;
  assign out_tlast  = r_last;

  `PPC_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid, "output valid after reset")
  `PPC_ASSERT(a_ready, in_tready == (!out_tvalid || out_tready), "input ready mismatch")

endmodule

// ----- sv/ppc_dist.sv -----
module ppc_dist (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  ppc_pkg::part_t   in_p,
  input  ppc_pkg::plane_t  pl,
  output logic             out_v,
  output ppc_pkg::part_t   out_p,
  output logic             out_hit,
  output logic [ppc_pkg::DIST_W-1:0] out_tot,
  output logic [ppc_pkg::DIST_W-1:0] out_rem
);
  import ppc_pkg::*;

  logic                       s1_v_r, s2_v_r, s3_v_r;
  part_t                      s1_p_r, s2_p_r, s3_p_r;
  logic signed [PROD_W-1:0]   s1_ps_r [3];
  logic signed [PROD_W-1:0]   s1_pe_r [3];
  logic signed [DIST_W-1:0]   s2_ds_r, s2_de_r;
  logic                       s3_hit_r;
  logic [DIST_W-1:0]          s3_tot_r, s3_rem_r;
  logic signed [DIST_W-1:0]   offx;

  // offset scaled into Q20.32
  assign offx = $signed({{(DIST_W-Q_W-FRAC_BITS){pl.off[Q_W-1]}}, pl.off, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r <= in_p;
      for (int i = 0; i < 3; i++) begin
        s1_ps_r[i] <= $signed(pl.n[i]) * $signed(in_p.sp[i]);
        s1_pe_r[i] <= $signed(pl.n[i]) * $signed(in_p.ep[i]);
      end
      s2_p_r  <= s1_p_r;
      s2_ds_r <= DIST_W'(s1_ps_r[0]) + DIST_W'(s1_ps_r[1]) + DIST_W'(s1_ps_r[2]) + offx;
      s2_de_r <= DIST_W'(s1_pe_r[0]) + DIST_W'(s1_pe_r[1]) + DIST_W'(s1_pe_r[2]) + offx;
      s3_p_r   <= s2_p_r;
      s3_hit_r <= s2_de_r[DIST_W-1] && !s2_ds_r[DIST_W-1];
      s3_tot_r <= s2_ds_r - s2_de_r;
      s3_rem_r <= s2_ds_r;
    end
  end

  assign out_v   = s3_v_r;
  assign out_p   = s3_p_r;
  assign out_hit = s3_hit_r;
  assign out_tot = s3_tot_r;
  assign out_rem = s3_rem_r;

endmodule

// ----- sv/ppc_div.sv -----
`include "particle_plane_collision_macros.svh"
module ppc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  ppc_pkg::part_t   in_p,
  input  logic             in_hit,
  input  logic [ppc_pkg::DIST_W-1:0] in_tot,
  input  logic [ppc_pkg::DIST_W-1:0] in_rem,
  output logic             out_v,
  output ppc_pkg::part_t   out_p,
  output logic             out_hit,
  output logic [ppc_pkg::FRAC_BITS-1:0] out_frac
);
  import ppc_pkg::*;

  localparam int NSTEP = FRAC_BITS;

  logic                 v_r   [NSTEP];
  part_t                p_r   [NSTEP];
  logic                 hit_r [NSTEP];
  logic [DIST_W-1:0]    tot_r [NSTEP];
  logic [DIST_W-1:0]    rem_r [NSTEP];
  logic [NSTEP-1:0]     q_r   [NSTEP];

  // one quotient bit per stage, restoring
  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    logic              v_in, hit_in;
    part_t             p_in;
    logic [DIST_W-1:0] tot_in, rem_in;
    logic [NSTEP-1:0]  q_in;
    logic [DIST_W:0]   rem_sh, rem_sub;
    logic              ge;

    if (g == 0) begin : g_first
      assign v_in   = in_v;
      assign p_in   = in_p;
      assign hit_in = in_hit;
      assign tot_in = in_tot;
      assign rem_in = in_rem;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = v_r[g-1];
      assign p_in   = p_r[g-1];
      assign hit_in = hit_r[g-1];
      assign tot_in = tot_r[g-1];
      assign rem_in = rem_r[g-1];
      assign q_in   = q_r[g-1];
    end

    assign rem_sh  = {rem_in, 1'b0};
    assign rem_sub = rem_sh - {1'b0, tot_in};
    assign ge      = rem_sh >= {1'b0, tot_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[g]   <= p_in;
        hit_r[g] <= hit_in;
        tot_r[g] <= tot_in;
        rem_r[g] <= ge ? rem_sub[DIST_W-1:0] : rem_sh[DIST_W-1:0];
        q_r[g]   <= {q_in[NSTEP-2:0], ge};
      end
    end
  end

  assign out_v    = v_r[NSTEP-1];
  assign out_p    = p_r[NSTEP-1];
  assign out_hit  = hit_r[NSTEP-1];
  assign out_frac = q_r[NSTEP-1];

  // remainder stays below the divisor for a real hit
  `PPC_ASSERT(a_rem_first, (v_r[0] && hit_r[0]) |-> (rem_r[0] < tot_r[0]), "first step remainder overflow")
  `PPC_ASSERT(a_rem_last, (out_v && out_hit) |-> (rem_r[NSTEP-1] < tot_r[NSTEP-1]), "last step remainder overflow")
  `PPC_ASSERT(a_adv, (en && v_r[NSTEP-2]) |=> v_r[NSTEP-1], "divider lost an item")

endmodule

// ----- sv/ppc_resp.sv -----
module ppc_resp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  ppc_pkg::part_t   in_p,
  input  logic             in_hit,
  input  logic [ppc_pkg::FRAC_BITS-1:0] in_frac,
  input  ppc_pkg::plane_t  pl,
  output logic             out_v,
  output ppc_pkg::q_t      pos [3],
  output ppc_pkg::q_t      vel [3],
  output logic             collided,
  output logic             last
);
  import ppc_pkg::*;

  logic signed [R_W:0] rs;
  assign rs = $signed({1'b0, pl.rest});

  logic        v_r [8];
  part_t       p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  logic        h1_r, h2_r, h3_r, h4_r, h5_r, h6_r, h7_r;

  logic signed [32:0] ste1_r [3];
  logic signed [49:0] prod1_r [3];
  logic signed [49:0] nv1_r [3];
  logic signed [33:0] sth2_r [3], sth3_r [3], sth4_r [3], sth5_r [3], sth6_r [3], sth7_r [3];
  logic signed [34:0] hte2_r [3], hte3_r [3], hte4_r [3], hte5_r [3];
  logic signed [36:0] kv2_r, kv3_r;
  logic signed [52:0] nh3_r [3];
  logic signed [54:0] nkv3_r [3];
  logic signed [39:0] k4_r;
  logic signed [39:0] vref4_r [3];
  logic signed [57:0] nk5_r [3];
  logic signed [58:0] rv5_r [3];
  logic signed [42:0] refl6_r [3];
  q_t                 vel6_r [3], vel7_r [3];
  logic signed [61:0] rr7_r [3];
  q_t                 pos_r [3], vel_r [3];
  logic               coll_r, last_r;

  logic signed [32:0] ste_c [3];
  logic signed [51:0] vsum_c;
  logic signed [54:0] hsum_c;
  logic signed [47:0] pos_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ste_c[i] = 33'(in_p.ep[i]) - 33'(in_p.sp[i]);
      pos_c[i] = 48'(p7_r.sp[i]) + 48'(sth7_r[i]) + 48'($signed(rr7_r[i][61:16]));
    end
    vsum_c = 52'(nv1_r[0]) + 52'(nv1_r[1]) + 52'(nv1_r[2]);
    hsum_c = 55'(nh3_r[0]) + 55'(nh3_r[1]) + 55'(nh3_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 8; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int s = 1; s < 8; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // move to the hit point, velocity dot
      p1_r <= in_p;
      h1_r <= in_hit;
      for (int i = 0; i < 3; i++) begin
        ste1_r[i]  <= ste_c[i];
        prod1_r[i] <= ste_c[i] * $signed({1'b0, in_frac});
        nv1_r[i]   <= $signed(pl.n[i]) * $signed(in_p.vel[i]);
      end
      // split the move at the hit
      p2_r  <= p1_r;
      h2_r  <= h1_r;
      kv2_r <= $signed({vsum_c[51:16], 1'b0});
      for (int i = 0; i < 3; i++) begin
        sth2_r[i] <= $signed(prod1_r[i][49:16]);
        hte2_r[i] <= 35'(ste1_r[i]) - 35'($signed(prod1_r[i][49:16]));
      end
      // normal products
      p3_r  <= p2_r;
      h3_r  <= h2_r;
      kv3_r <= kv2_r;
      for (int i = 0; i < 3; i++) begin
        sth3_r[i] <= sth2_r[i];
        hte3_r[i] <= hte2_r[i];
        nh3_r[i]  <= $signed(pl.n[i]) * hte2_r[i];
        nkv3_r[i] <= $signed(pl.n[i]) * kv2_r;
      end
      // reflection factor less one LSB, reflected velocity
      p4_r <= p3_r;
      h4_r <= h3_r;
      k4_r <= $signed({hsum_c[54:16], 1'b0}) - 40'sd1;
      for (int i = 0; i < 3; i++) begin
        sth4_r[i]  <= sth3_r[i];
        hte4_r[i]  <= hte3_r[i];
        vref4_r[i] <= 40'(p3_r.vel[i]) - 40'($signed(nkv3_r[i][54:16]));
      end
      // reflect the move, scale the velocity
      p5_r <= p4_r;
      h5_r <= h4_r;
      for (int i = 0; i < 3; i++) begin
        sth5_r[i] <= sth4_r[i];
        hte5_r[i] <= hte4_r[i];
        nk5_r[i]  <= $signed(pl.n[i]) * k4_r;
        rv5_r[i]  <= rs * vref4_r[i];
      end
      p6_r <= p5_r;
      h6_r <= h5_r;
      for (int i = 0; i < 3; i++) begin
        sth6_r[i]  <= sth5_r[i];
        refl6_r[i] <= 43'(hte5_r[i]) - 43'($signed(nk5_r[i][57:16]));
        vel6_r[i]  <= sat32(48'($signed(rv5_r[i][58:16])));
      end
      // scale the reflected move
      p7_r <= p6_r;
      h7_r <= h6_r;
      for (int i = 0; i < 3; i++) begin
        sth7_r[i] <= sth6_r[i];
        vel7_r[i] <= vel6_r[i];
        rr7_r[i]  <= rs * refl6_r[i];
      end
      // output register: response or pass-through
      coll_r <= h7_r;
      last_r <= p7_r.last;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= h7_r ? sat32(pos_c[i]) : p7_r.ep[i];
        vel_r[i] <= h7_r ? vel7_r[i] : p7_r.vel[i];
      end
    end
  end

  assign out_v    = v_r[7];
  assign pos      = pos_r;
  assign vel      = vel_r;
  assign collided = coll_r;
  assign last     = last_r;

endmodule
